// File: sv/text_mode_console_writer_defines.svh
// ----------------------------------------------------------------------------
// Text mode console writer - assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_MODE_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_MODE_CONSOLE_WRITER_DEFINES_SVH

// Same-cycle implication.
`define TMCW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TMCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/tmcw_pkg.sv
// ----------------------------------------------------------------------------
// tmcw_pkg
// Geometry, codes and controller/datapath interface types of the console.
// ----------------------------------------------------------------------------
package tmcw_pkg;

  localparam int COLUMNS       = 80;
  localparam int ROWS          = 25;
  localparam int CELLS         = ROWS * COLUMNS;
  localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ADDR_W = 11;
  localparam int CELL_W = 16;

  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_BLANK     = 8'h20;
  localparam logic [7:0] INIT_ATTR    = 8'h0F;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  // Datapath operations issued by the controller.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_INIT,    // reset blank at sweep pointer
    OP_EXEC,    // act on the latched transaction
    OP_FILL,    // blank with latched attribute at sweep pointer
    OP_SCROLL,  // read one row down, write the previously read cell
    OP_FLUSH    // write the last cell read by the scroll
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   in_load;
    logic   out_load;
  } ctl_t;

  typedef struct packed {
    cmd_e cmd;
    logic scroll;
    logic ptr_last;
    logic ptr_bottom;
  } stat_t;

endpackage

// File: sv/tmcw_ctrl.sv
// ----------------------------------------------------------------------------
// tmcw_ctrl
// Sequencer: clearing pass, item execution, scroll and fill sweeps, result.
// ----------------------------------------------------------------------------
`include "text_mode_console_writer_defines.svh"

module tmcw_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  tmcw_pkg::stat_t stat_i,
  output tmcw_pkg::ctl_t  ctl_o
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_SCROLL,
    S_BLANK,
    S_FILL,
    S_FIN
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  always_comb begin
    ctl_o          = '0;
    ctl_o.op       = tmcw_pkg::OP_NONE;
    case (state_q)
      S_INIT:   ctl_o.op = tmcw_pkg::OP_INIT;
      S_IDLE:   ctl_o.in_load = in_valid_i;
      S_EXEC:   ctl_o.op = tmcw_pkg::OP_EXEC;
      S_SCROLL: ctl_o.op = stat_i.ptr_bottom ? tmcw_pkg::OP_FLUSH : tmcw_pkg::OP_SCROLL;
      S_BLANK:  ctl_o.op = tmcw_pkg::OP_FILL;
      S_FILL:   ctl_o.op = tmcw_pkg::OP_FILL;
      S_FIN:    ctl_o.out_load = !out_valid_q || !out_stall_i;
      default:  ctl_o.op = tmcw_pkg::OP_NONE;
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_INIT: begin
          if (stat_i.ptr_last) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i) state_q <= S_EXEC;
        end
        S_EXEC: begin
          case (stat_i.cmd)
            tmcw_pkg::CMD_PUT:   state_q <= stat_i.scroll ? S_SCROLL : S_FIN;
            tmcw_pkg::CMD_CLEAR: state_q <= S_FILL;
            default:             state_q <= S_FIN;
          endcase
        end
        S_SCROLL: begin
          if (stat_i.ptr_bottom) state_q <= S_BLANK;
        end
        S_BLANK, S_FILL: begin
          if (stat_i.ptr_last) state_q <= S_FIN;
        end
        S_FIN: begin
          if (ctl_o.out_load) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `TMCW_ASSERT_NEXT(a_accept_exec, in_valid_i && !in_stall_o, state_q == S_EXEC, "accepted transaction did not start execution")
  `TMCW_ASSERT_NOW(a_no_overwrite, ctl_o.out_load, !out_valid_q || !out_stall_i, "result register overwritten while stalled")

endmodule

// File: sv/tmcw_datapath.sv
// ----------------------------------------------------------------------------
// tmcw_datapath
// Frame buffer memory, cursor, sweep pointer and result register.
// ----------------------------------------------------------------------------
`include "text_mode_console_writer_defines.svh"

module tmcw_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tmcw_pkg::ctl_t                ctl_i,
  output tmcw_pkg::stat_t               stat_o,
  input  logic [1:0]                    cmd_i,
  input  logic [7:0]                    char_code_i,
  input  logic [7:0]                    attribute_color_i,
  input  logic [tmcw_pkg::ADDR_W-1:0]   cell_index_i,
  output logic [tmcw_pkg::COL_W-1:0]    cursor_col_o,
  output logic [tmcw_pkg::ROW_W-1:0]    cursor_row_o,
  output logic [tmcw_pkg::ADDR_W-1:0]   cursor_pos_o,
  output logic [tmcw_pkg::CELL_W-1:0]   cell_data_o,
  output logic                          scrolled_o
);

  localparam int AW = tmcw_pkg::ADDR_W;
  localparam int CW = tmcw_pkg::COL_W;
  localparam int RW = tmcw_pkg::ROW_W;
  localparam int DW = tmcw_pkg::CELL_W;

  logic [DW-1:0] mem [tmcw_pkg::CELLS];

  tmcw_pkg::cmd_e cmd_q;
  logic [7:0]     code_q;
  logic [7:0]     attr_q;
  logic [AW-1:0]  idx_q;

  logic [CW-1:0]  cur_col_q, cur_col_d;
  logic [RW-1:0]  cur_row_q, cur_row_d;
  logic [AW-1:0]  ptr_q, lag_q;
  logic [DW-1:0]  rdata_q;
  logic           rd_ok_q, scroll_q;

  logic [CW-1:0]  col_o_q;
  logic [RW-1:0]  row_o_q;
  logic [AW-1:0]  pos_o_q;
  logic [DW-1:0]  data_o_q;
  logic           scr_o_q;

  logic [AW-1:0]  pos;
  logic [CW:0]    col_n;
  logic [RW:0]    row_n;
  logic           need_scroll;
  logic           idx_ok;
  logic           we, re;
  logic [AW-1:0]  waddr, raddr;
  logic [DW-1:0]  wdata;
  logic [DW-1:0]  blank;
  logic           is_exec;

  assign pos     = AW'(cur_row_q) * AW'(tmcw_pkg::COLUMNS) + AW'(cur_col_q);
  assign blank   = {attr_q, tmcw_pkg::CH_BLANK};
  assign idx_ok  = idx_q < AW'(tmcw_pkg::CELLS);
  assign is_exec = (ctl_i.op == tmcw_pkg::OP_EXEC);

  // Cursor motion of a put transaction.
  always_comb begin
    col_n = {1'b0, cur_col_q};
    row_n = {1'b0, cur_row_q};
    if (code_q == tmcw_pkg::CH_NEWLINE) begin
      col_n = '0;
      row_n = row_n + 1'b1;
    end else if (code_q == tmcw_pkg::CH_BACKSPACE) begin
      if (cur_col_q != '0) col_n = col_n - 1'b1;
    end else begin
      col_n = col_n + 1'b1;
    end
    if (col_n >= (CW+1)'(tmcw_pkg::COLUMNS)) begin
      col_n = '0;
      row_n = row_n + 1'b1;
    end
    need_scroll = (row_n >= (RW+1)'(tmcw_pkg::ROWS));
    if (need_scroll) row_n = (RW+1)'(tmcw_pkg::ROWS - 1);
  end

  // Memory port selection.
  always_comb begin
    we    = 1'b0;
    waddr = ptr_q;
    wdata = blank;
    re    = 1'b0;
    raddr = idx_q;
    case (ctl_i.op)
      tmcw_pkg::OP_INIT: begin
        we    = 1'b1;
        wdata = {tmcw_pkg::INIT_ATTR, tmcw_pkg::CH_BLANK};
      end
      tmcw_pkg::OP_FILL: we = 1'b1;
      tmcw_pkg::OP_EXEC: begin
        if (cmd_q == tmcw_pkg::CMD_PUT) begin
          if (code_q == tmcw_pkg::CH_BACKSPACE) begin
            we    = (cur_col_q != '0);
            waddr = pos - 1'b1;
          end else if (code_q != tmcw_pkg::CH_NEWLINE) begin
            we    = 1'b1;
            waddr = pos;
            wdata = {attr_q, code_q};
          end
        end
        re = (cmd_q == tmcw_pkg::CMD_READ) && idx_ok;
      end
      tmcw_pkg::OP_SCROLL: begin
        re    = 1'b1;
        raddr = ptr_q + AW'(tmcw_pkg::COLUMNS);
        we    = (ptr_q != '0);
        waddr = lag_q;
        wdata = rdata_q;
      end
      tmcw_pkg::OP_FLUSH: begin
        we    = 1'b1;
        waddr = lag_q;
        wdata = rdata_q;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  always_comb begin
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    if (is_exec) begin
      case (cmd_q)
        tmcw_pkg::CMD_PUT: begin
          cur_col_d = col_n[CW-1:0];
          cur_row_d = row_n[RW-1:0];
        end
        tmcw_pkg::CMD_CLEAR: begin
          cur_col_d = '0;
          cur_row_d = '0;
        end
        default: cur_col_d = cur_col_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q <= '0;
      cur_row_q <= '0;
      ptr_q     <= '0;
      rd_ok_q   <= 1'b0;
      scroll_q  <= 1'b0;
    end else begin
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
      case (ctl_i.op)
        tmcw_pkg::OP_EXEC: begin
          ptr_q    <= '0;
          rd_ok_q  <= (cmd_q == tmcw_pkg::CMD_READ) && idx_ok;
          scroll_q <= (cmd_q == tmcw_pkg::CMD_PUT) && need_scroll;
        end
        tmcw_pkg::OP_INIT, tmcw_pkg::OP_FILL, tmcw_pkg::OP_SCROLL: begin
          if (ptr_q != AW'(tmcw_pkg::CELLS - 1)) ptr_q <= ptr_q + 1'b1;
        end
        default: ptr_q <= ptr_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.op == tmcw_pkg::OP_SCROLL) lag_q <= ptr_q;
    if (ctl_i.in_load) begin
      cmd_q  <= tmcw_pkg::cmd_e'(cmd_i);
      code_q <= char_code_i;
      attr_q <= attribute_color_i;
      idx_q  <= cell_index_i;
    end
    if (ctl_i.out_load) begin
      col_o_q  <= cur_col_q;
      row_o_q  <= cur_row_q;
      pos_o_q  <= pos;
      data_o_q <= rd_ok_q ? rdata_q : '0;
      scr_o_q  <= scroll_q;
    end
  end

  assign stat_o.cmd        = cmd_q;
  assign stat_o.scroll     = need_scroll;
  assign stat_o.ptr_last   = (ptr_q == AW'(tmcw_pkg::CELLS - 1));
  assign stat_o.ptr_bottom = (ptr_q == AW'(tmcw_pkg::LAST_ROW_BASE));

  assign cursor_col_o = col_o_q;
  assign cursor_row_o = row_o_q;
  assign cursor_pos_o = pos_o_q;
  assign cell_data_o  = data_o_q;
  assign scrolled_o   = scr_o_q;

  `TMCW_ASSERT_NOW(a_cursor_range, 1'b1, (32'(cur_col_q) < tmcw_pkg::COLUMNS) && (32'(cur_row_q) < tmcw_pkg::ROWS), "cursor outside the screen")
  `TMCW_ASSERT_NOW(a_scroll_window, ctl_i.op == tmcw_pkg::OP_SCROLL, 32'(ptr_q) < tmcw_pkg::LAST_ROW_BASE, "scroll read beyond last row")

endmodule

// File: sv/text_mode_console_writer.sv
// ----------------------------------------------------------------------------
// text_mode_console_writer
// 80x25 text console: put character, clear screen and cell readback over a
// single-port-write frame buffer, reporting the cursor after every item.
// ----------------------------------------------------------------------------
//   channel | direction | handshake            | payload
//   in      | input     | in_valid_i/in_stall_o | cmd, char_code, attribute_color,
//           |           |                      | cell_index
//   out     | output    | out_valid_o/out_stall_i | cursor_col, cursor_row,
//           |           |                      | cursor_pos, cell_data, scrolled
//
// After reset the frame buffer is blanked (0x0F20) by a clearing pass over
// every cell; in_stall_o stays high until it completes.
// Put, read and no-op items go through the execute and result states before
// the result is registered; no new item is taken until the sequencer is idle.
// A put that scrolls and a clear both sweep every cell: the frame buffer
// has one write port, so each cell is moved or blanked in its own cycle
// (each scroll write follows its read in the next cycle).
// One item is in execution at a time; the next is accepted while the
// previous result is still held on a stalled output.
// ----------------------------------------------------------------------------
module text_mode_console_writer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  cmd_i,
  input  logic [7:0]                  char_code_i,
  input  logic [7:0]                  attribute_color_i,
  input  logic [tmcw_pkg::ADDR_W-1:0] cell_index_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [tmcw_pkg::COL_W-1:0]  cursor_col_o,
  output logic [tmcw_pkg::ROW_W-1:0]  cursor_row_o,
  output logic [tmcw_pkg::ADDR_W-1:0] cursor_pos_o,
  output logic [tmcw_pkg::CELL_W-1:0] cell_data_o,
  output logic                        scrolled_o
);

  // Command bundle from the sequencer and status back from the datapath.
  tmcw_pkg::ctl_t  ctl;
  tmcw_pkg::stat_t stat;

  // Sequencer: owns the handshakes and the sweep sequencing.
  tmcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .ctl_o       (ctl)
  );

  // Datapath: frame buffer, cursor and result register.
  tmcw_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctl_i             (ctl),
    .stat_o            (stat),
    .cmd_i             (cmd_i),
    .char_code_i       (char_code_i),
    .attribute_color_i (attribute_color_i),
    .cell_index_i      (cell_index_i),
    .cursor_col_o      (cursor_col_o),
    .cursor_row_o      (cursor_row_o),
    .cursor_pos_o      (cursor_pos_o),
    .cell_data_o       (cell_data_o),
    .scrolled_o        (scrolled_o)
  );

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - text mode console writer testbench
// Drives put, clear, read and unused-command transactions into the console
// and checks every result against an in-bench shadow of the frame buffer and
// cursor. Both handshake sides idle at random, and the output side also holds
// off for one long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int IDLE_LIMIT   = 20000; // cycles with no transaction on either side
  localparam int HOLD_CYCLES  = 400;   // long output hold-off
  localparam int DRAIN_CYCLES = 16;

  localparam int AW = tmcw_pkg::ADDR_W;
  localparam int DW = tmcw_pkg::CELL_W;

  // Cursor and readback as reported by one result transaction.
  typedef struct packed {
    logic [tmcw_pkg::COL_W-1:0]  col;
    logic [tmcw_pkg::ROW_W-1:0]  row;
    logic [tmcw_pkg::ADDR_W-1:0] pos;
    logic [tmcw_pkg::CELL_W-1:0] data;
    logic                        scrolled;
  } console_report_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic [1:0]                  cmd_i;
  logic [7:0]                  char_code_i;
  logic [7:0]                  attribute_color_i;
  logic [tmcw_pkg::ADDR_W-1:0] cell_index_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic [tmcw_pkg::COL_W-1:0]  cursor_col_o;
  logic [tmcw_pkg::ROW_W-1:0]  cursor_row_o;
  logic [tmcw_pkg::ADDR_W-1:0] cursor_pos_o;
  logic [tmcw_pkg::CELL_W-1:0] cell_data_o;
  logic                        scrolled_o;

  // Shadow of the console: frame buffer plus cursor.
  logic [tmcw_pkg::CELL_W-1:0] shadow_cells [tmcw_pkg::CELLS];
  int                          model_col;
  int                          model_row;

  console_report_t   expected_reports [$];
  int                error_count   = 0;
  int                items_sent    = 0;
  bit                idle_enable   = 1'b1;
  bit                hold_request  = 1'b0;

  text_mode_console_writer u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .cmd_i             (cmd_i),
    .char_code_i       (char_code_i),
    .attribute_color_i (attribute_color_i),
    .cell_index_i      (cell_index_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .cursor_col_o      (cursor_col_o),
    .cursor_row_o      (cursor_row_o),
    .cursor_pos_o      (cursor_pos_o),
    .cell_data_o       (cell_data_o),
    .scrolled_o        (scrolled_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow model
  // --------------------------------------------------------------------------
  function automatic void fill_shadow(logic [7:0] attr);
    for (int i = 0; i < tmcw_pkg::CELLS; i++) shadow_cells[i] = {attr, tmcw_pkg::CH_BLANK};
  endfunction

  function automatic void reset_shadow();
    fill_shadow(tmcw_pkg::INIT_ATTR);
    model_col = 0;
    model_row = 0;
  endfunction

  // Apply one accepted transaction and queue the result it must produce.
  function automatic void apply_console_item(tmcw_pkg::cmd_e cmd, logic [7:0] code,
                                             logic [7:0] attr,
                                             logic [tmcw_pkg::ADDR_W-1:0] idx);
    console_report_t rep;
    int              lin;
    rep = '0;
    case (cmd)
      tmcw_pkg::CMD_PUT: begin
        if (code == tmcw_pkg::CH_NEWLINE) begin
          model_col = 0;
          model_row++;
        end else if (code == tmcw_pkg::CH_BACKSPACE) begin
          // no-op at column zero, no reverse wrap
          if (model_col > 0) begin
            model_col--;
            shadow_cells[model_row * tmcw_pkg::COLUMNS + model_col] =
              {attr, tmcw_pkg::CH_BLANK};
          end
        end else begin
          shadow_cells[model_row * tmcw_pkg::COLUMNS + model_col] = {attr, code};
          model_col++;
        end
        if (model_col >= tmcw_pkg::COLUMNS) begin
          model_col = 0;
          model_row++;
        end
        if (model_row >= tmcw_pkg::ROWS) begin
          // scroll up one row, bottom row blanked with this item's attribute
          for (int i = 0; i < tmcw_pkg::LAST_ROW_BASE; i++)
            shadow_cells[i] = shadow_cells[i + tmcw_pkg::COLUMNS];
          for (int i = tmcw_pkg::LAST_ROW_BASE; i < tmcw_pkg::CELLS; i++)
            shadow_cells[i] = {attr, tmcw_pkg::CH_BLANK};
          model_row    = tmcw_pkg::ROWS - 1;
          rep.scrolled = 1'b1;
        end
      end
      tmcw_pkg::CMD_CLEAR: begin
        fill_shadow(attr);
        model_col = 0;
        model_row = 0;
      end
      tmcw_pkg::CMD_READ: begin
        if (idx < tmcw_pkg::CELLS) rep.data = shadow_cells[idx];
      end
      default: ;
    endcase
    lin     = model_row * tmcw_pkg::COLUMNS + model_col;
    rep.col = model_col[tmcw_pkg::COL_W-1:0];
    rep.row = model_row[tmcw_pkg::ROW_W-1:0];
    rep.pos = lin[tmcw_pkg::ADDR_W-1:0];
    expected_reports.push_back(rep);
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // Valid is left high after acceptance; it is only dropped when a gap starts
  // or the stimulus ends, so it never toggles twice in one time step.
  task automatic send_item(tmcw_pkg::cmd_e cmd, logic [7:0] code, logic [7:0] attr,
                           logic [tmcw_pkg::ADDR_W-1:0] idx);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    cmd_i             <= cmd;
    char_code_i       <= code;
    attribute_color_i <= attr;
    cell_index_i      <= idx;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    apply_console_item(cmd, code, attr, idx);
    items_sent++;
  endtask

  function automatic logic [7:0] random_glyph();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == tmcw_pkg::CH_NEWLINE || c == tmcw_pkg::CH_BACKSPACE);
    return c;
  endfunction

  task automatic put_char(logic [7:0] code, logic [7:0] attr);
    send_item(tmcw_pkg::CMD_PUT, code, attr, AW'($urandom_range(0, 2047)));
  endtask

  task automatic read_cell(logic [tmcw_pkg::ADDR_W-1:0] idx);
    send_item(tmcw_pkg::CMD_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              idx);
  endtask

  task automatic clear_console(logic [7:0] attr);
    send_item(tmcw_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)), attr,
              AW'($urandom_range(0, 2047)));
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Response side: random stall bursts, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : receiver
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_request = 1'b0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic void check_field(string name, logic [tmcw_pkg::CELL_W-1:0] want,
                                      logic [tmcw_pkg::CELL_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    console_report_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual col %0d row %0d data %0h",
                 $time, cursor_col_o, cursor_row_o, cell_data_o);
        error_count++;
      end else begin
        want = expected_reports.pop_front();
        check_field("cursor_col", DW'(want.col), DW'(cursor_col_o));
        check_field("cursor_row", DW'(want.row), DW'(cursor_row_o));
        check_field("cursor_pos", DW'(want.pos), DW'(cursor_pos_o));
        check_field("cell_data", want.data, cell_data_o);
        check_field("scrolled", DW'(want.scrolled), DW'(scrolled_o));
      end
    end
  end

  // Ends the run if neither side moves a transaction for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Frame buffer contents left by the clearing pass, and reads past the end.
  task automatic test_reset_contents();
    read_cell(AW'(0));
    read_cell(AW'(tmcw_pkg::CELLS - 1));
    read_cell(AW'(tmcw_pkg::CELLS));
    read_cell(11'h7FF);
    read_cell(AW'($urandom_range(1, tmcw_pkg::CELLS - 2)));
  endtask

  // Backspace at column zero, glyph byte extremes, backspace, newline, unused cmd.
  task automatic test_control_codes();
    put_char(tmcw_pkg::CH_BACKSPACE, 8'hAA);
    put_char(8'h00, 8'h00);
    put_char(8'hFF, 8'hFF);
    put_char(8'h41, 8'h1E);
    read_cell(AW'(0));
    read_cell(AW'(1));
    read_cell(AW'(2));
    put_char(tmcw_pkg::CH_BACKSPACE, 8'h70);
    read_cell(AW'(2));
    put_char(tmcw_pkg::CH_NEWLINE, 8'h0F);
    send_item(tmcw_pkg::CMD_NOP, 8'hFF, 8'hFF, 11'h7FF);
    send_item(tmcw_pkg::CMD_NOP, 8'h00, 8'h00, 11'h000);
    read_cell(AW'(tmcw_pkg::COLUMNS));
  endtask

  task automatic test_clear_console();
    clear_console(8'h00);
    read_cell(AW'(0));
    put_char(8'h5A, 8'h2F);
    clear_console(8'hFF);
    read_cell(AW'(tmcw_pkg::CELLS - 1));
  endtask

  // A full line of glyphs from home; the last one wraps the cursor.
  task automatic test_line_wrap();
    clear_console(8'h07);
    repeat (tmcw_pkg::COLUMNS) put_char(random_glyph(), 8'($urandom_range(0, 255)));
    read_cell(AW'(tmcw_pkg::COLUMNS - 1));
    read_cell(AW'(tmcw_pkg::COLUMNS));
    put_char(tmcw_pkg::CH_BACKSPACE, 8'h33);
  endtask

  // Walk down to the bottom row, then scroll with a newline.
  task automatic test_scroll();
    while (model_row < tmcw_pkg::ROWS - 1)
      put_char(tmcw_pkg::CH_NEWLINE, 8'($urandom_range(0, 255)));
    put_char(8'h78, 8'h2A);
    put_char(tmcw_pkg::CH_NEWLINE, 8'h4E);
    read_cell(AW'(tmcw_pkg::LAST_ROW_BASE - tmcw_pkg::COLUMNS));
    read_cell(AW'(tmcw_pkg::LAST_ROW_BASE));
    read_cell(AW'(tmcw_pkg::CELLS - 1));
    put_char(tmcw_pkg::CH_BACKSPACE, 8'h11);
  endtask

  // Output held off while requests keep coming: the block must stall its input.
  task automatic test_output_backpressure();
    hold_request = 1'b1;
    repeat (6) begin
      put_char(random_glyph(), 8'($urandom_range(0, 255)));
      read_cell(AW'($urandom_range(0, tmcw_pkg::CELLS - 1)));
    end
  endtask

  // Mostly text lines with random content; some backspaces, readback, rare
  // clears, and a share of fully random transactions.
  task automatic test_random_traffic(int n_items);
    int first;
    int kind;
    int len;
    int pos;
    first = items_sent;
    while (items_sent - first < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        len = ($urandom_range(0, 11) == 0) ? $urandom_range(70, 85) : $urandom_range(0, 12);
        repeat (len) put_char(random_glyph(), 8'($urandom_range(0, 255)));
        put_char(tmcw_pkg::CH_NEWLINE, 8'($urandom_range(0, 255)));
      end else if (kind < 68) begin
        repeat ($urandom_range(1, 4))
          put_char(tmcw_pkg::CH_BACKSPACE, 8'($urandom_range(0, 255)));
      end else if (kind < 86) begin
        pos = model_row * tmcw_pkg::COLUMNS + model_col - $urandom_range(0, 3);
        if (pos < 0) pos = 0;
        read_cell(AW'(($urandom_range(0, 1) == 0) ? pos : $urandom_range(0, 2047)));
      end else if (kind < 89) begin
        clear_console(8'($urandom_range(0, 255)));
      end else begin
        send_item(tmcw_pkg::cmd_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), AW'($urandom_range(0, 2047)));
      end
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    cmd_i             = tmcw_pkg::CMD_NOP;
    char_code_i       = '0;
    attribute_color_i = '0;
    cell_index_i      = '0;
    reset_shadow();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_contents();
    test_control_codes();
    test_clear_console();
    test_line_wrap();
    test_scroll();
    test_output_backpressure();
    test_random_traffic(110);

    // closing stretch: no idling on either side
    idle_enable = 1'b0;
    test_random_traffic(40);

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0 && expected_reports.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/tmcw_pkg.sv
sv/tmcw_ctrl.sv
sv/tmcw_datapath.sv
sv/text_mode_console_writer.sv
tb/tb_top.sv
